### sv/kmsd_pkg.sv
// kmsd_pkg: shared constants, types and the report code rom for the key matrix scanner
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package kmsd_pkg;

  localparam int NUM_COLUMNS = 5;
  localparam int NUM_ROWS    = 8;

  localparam int COL_W  = 3;
  localparam int ROW_W  = 4;
  localparam int SC_W   = 6;
  localparam int CODE_W = 6;
  localparam int DB_W   = 8;
  localparam int LP_W   = 16;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [ROW_W-1:0] ROW_NONE  = 4'h0;
  localparam logic [ROW_W-1:0] ROW_MULTI = 4'hF;
  localparam logic [ROW_W-1:0] ROW_LAST  = 4'd8;

  localparam logic [DB_W-1:0] DEBOUNCE_RESET  = 8'd10;
  localparam logic [LP_W-1:0] LONG_RESET      = 16'd1000;
  localparam logic [SC_W-1:0] WATCHED_RESET   = 6'd0;

  // register indexes (word address bits)
  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_LONG     = 2'd1;
  localparam logic [1:0] REG_WATCHED  = 2'd2;

  typedef enum logic [5:0] {
    PH_IDLE          = 6'b000001,
    PH_WAIT_PRESSED  = 6'b000010,
    PH_PRESSED       = 6'b000100,
    PH_WAIT_RELEASED = 6'b001000,
    PH_MULTI         = 6'b010000,
    PH_WAIT_MULTI    = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [DB_W-1:0] debounce_ticks;
    logic [LP_W-1:0] long_press_ticks;
    logic [SC_W-1:0] watched_scan_code;
  } cfg_t;

  typedef struct packed {
    logic [COL_W-1:0]  column_index;
    logic              event_valid;
    logic              event_pressed;
    logic              event_long;
    logic [CODE_W-1:0] button_code;
    logic              watched_held;
  } res_t;

  // scan code to report code; codes not in the table (32 to 35 and past 39) read 0
  function automatic logic [CODE_W-1:0] report_rom(input logic [SC_W-1:0] sc);
    logic [CODE_W-1:0] c;
    case (sc)
      6'd0:  c = 6'd21;  6'd1:  c = 6'd22;  6'd2:  c = 6'd23;  6'd3:  c = 6'd24;
      6'd4:  c = 6'd25;  6'd5:  c = 6'd26;  6'd6:  c = 6'd27;  6'd7:  c = 6'd28;
      6'd8:  c = 6'd11;  6'd9:  c = 6'd3;   6'd10: c = 6'd1;   6'd11: c = 6'd50;
      6'd12: c = 6'd49;  6'd13: c = 6'd48;  6'd14: c = 6'd47;  6'd15: c = 6'd46;
      6'd16: c = 6'd40;  6'd17: c = 6'd37;  6'd18: c = 6'd34;  6'd19: c = 6'd31;
      6'd20: c = 6'd39;  6'd21: c = 6'd36;  6'd22: c = 6'd33;  6'd23: c = 6'd30;
      6'd24: c = 6'd45;  6'd25: c = 6'd44;  6'd26: c = 6'd43;  6'd27: c = 6'd42;
      6'd28: c = 6'd41;  6'd29: c = 6'd38;  6'd30: c = 6'd35;  6'd31: c = 6'd32;
      6'd36: c = 6'd29;  6'd37: c = 6'd9;   6'd38: c = 6'd7;   6'd39: c = 6'd5;
      default: c = 6'd0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

### sv/kmsd_rowcls.sv
// kmsd_rowcls: classes the active-low row sample as none, one row or several
// depends on kmsd_pkg
`timescale 1ns / 1ps
`default_nettype none

module kmsd_rowcls (
  input  wire logic [7:0]                  row_bits,
  output logic      [kmsd_pkg::ROW_W-1:0]  row_cls
);

  always_comb begin
    row_cls = kmsd_pkg::ROW_NONE;
    for (int r = 0; r < kmsd_pkg::NUM_ROWS; r++) begin
      if (!row_bits[r]) begin
        if (row_cls == kmsd_pkg::ROW_NONE) begin
          row_cls = kmsd_pkg::ROW_W'(r + 1);
        end else begin
          row_cls = kmsd_pkg::ROW_MULTI;
        end
      end
    end
  end

endmodule

`default_nettype wire

### sv/kmsd_seq.sv
// kmsd_seq: debounce counter, long-press counter and the scan phase sequencer
// depends on kmsd_pkg; produces one result per step
`timescale 1ns / 1ps
`default_nettype none

module kmsd_seq (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        step,
  input  wire logic [kmsd_pkg::ROW_W-1:0]  row_cls,
  input  wire kmsd_pkg::cfg_t              cfg,
  output kmsd_pkg::res_t                   res
);

  kmsd_pkg::phase_t                 phase, phase_next;
  logic [kmsd_pkg::COL_W-1:0]       column, column_next;
  logic [kmsd_pkg::ROW_W-1:0]       held_row, held_row_next;
  logic [kmsd_pkg::DB_W-1:0]        debounce_count, debounce_count_next;
  logic [kmsd_pkg::LP_W-1:0]        long_count, long_count_next;

  logic                             ev, ev_press, ev_long;
  logic                             cur_ok, nxt_ok;
  logic [kmsd_pkg::SC_W-1:0]        cur_sc, nxt_sc;
  logic [kmsd_pkg::CODE_W-1:0]      cur_code;

  // scan code of the held key, before and after this step
  assign cur_ok   = (held_row != kmsd_pkg::ROW_NONE) && (held_row <= kmsd_pkg::ROW_LAST);
  assign cur_sc   = {column, 3'(held_row - 4'd1)};
  assign cur_code = kmsd_pkg::report_rom(cur_sc);
  assign nxt_ok   = (held_row_next != kmsd_pkg::ROW_NONE) &&
                    (held_row_next <= kmsd_pkg::ROW_LAST);
  assign nxt_sc   = {column_next, 3'(held_row_next - 4'd1)};

  always_comb begin
    phase_next          = phase;
    column_next         = column;
    held_row_next       = held_row;
    debounce_count_next = debounce_count;
    long_count_next     = long_count;
    ev                  = 1'b0;
    ev_press            = 1'b0;
    ev_long             = 1'b0;
    if (debounce_count != '0) begin
      debounce_count_next = debounce_count - 8'd1;
    end else begin
      case (phase)
        kmsd_pkg::PH_WAIT_PRESSED: begin
          if (row_cls == held_row) begin
            phase_next      = kmsd_pkg::PH_PRESSED;
            ev              = 1'b1;
            ev_press        = 1'b1;
            long_count_next = cfg.long_press_ticks;
          end else begin
            phase_next          = kmsd_pkg::PH_MULTI;
            debounce_count_next = cfg.debounce_ticks;
          end
        end
        kmsd_pkg::PH_PRESSED: begin
          if (row_cls == kmsd_pkg::ROW_NONE) begin
            phase_next          = kmsd_pkg::PH_WAIT_RELEASED;
            debounce_count_next = cfg.debounce_ticks;
          end else if (row_cls != held_row) begin
            phase_next          = kmsd_pkg::PH_MULTI;
            debounce_count_next = cfg.debounce_ticks;
            ev                  = 1'b1;
          end else if (long_count != '0) begin
            long_count_next = long_count - 16'd1;
            if (long_count == 16'd1) begin
              ev       = 1'b1;
              ev_press = 1'b1;
              ev_long  = 1'b1;
            end
          end
        end
        kmsd_pkg::PH_WAIT_RELEASED: begin
          if (row_cls == kmsd_pkg::ROW_NONE) begin
            phase_next          = kmsd_pkg::PH_IDLE;
            debounce_count_next = cfg.debounce_ticks;
            ev                  = 1'b1;
          end else if (row_cls != held_row) begin
            phase_next          = kmsd_pkg::PH_MULTI;
            debounce_count_next = cfg.debounce_ticks;
          end
        end
        kmsd_pkg::PH_MULTI: begin
          if (row_cls == kmsd_pkg::ROW_NONE) begin
            phase_next          = kmsd_pkg::PH_WAIT_MULTI;
            debounce_count_next = cfg.debounce_ticks;
          end
        end
        kmsd_pkg::PH_WAIT_MULTI: begin
          phase_next = (row_cls == kmsd_pkg::ROW_NONE) ? kmsd_pkg::PH_IDLE
                                                        : kmsd_pkg::PH_MULTI;
          debounce_count_next = cfg.debounce_ticks;
        end
        default: begin
          phase_next = kmsd_pkg::PH_IDLE;
          if (row_cls == kmsd_pkg::ROW_NONE) begin
            if (column >= kmsd_pkg::COL_W'(kmsd_pkg::NUM_COLUMNS - 1)) begin
              column_next = '0;
            end else begin
              column_next = column + 3'd1;
            end
          end else if (row_cls == kmsd_pkg::ROW_MULTI) begin
            phase_next          = kmsd_pkg::PH_MULTI;
            debounce_count_next = cfg.debounce_ticks;
          end else begin
            phase_next          = kmsd_pkg::PH_WAIT_PRESSED;
            held_row_next       = row_cls;
            debounce_count_next = cfg.debounce_ticks;
          end
        end
      endcase
    end
  end

  // an event only goes out with a nonzero report code
  always_comb begin
    logic fire;
    fire                = ev && cur_ok && (cur_code != '0);
    res.column_index    = column_next;
    res.event_valid     = fire;
    res.event_pressed   = fire && ev_press;
    res.event_long      = fire && ev_long;
    res.button_code     = fire ? cur_code : '0;
    res.watched_held    = (phase_next == kmsd_pkg::PH_PRESSED) && nxt_ok &&
                          (nxt_sc == cfg.watched_scan_code);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= kmsd_pkg::PH_IDLE;
      column         <= '0;
      held_row       <= '0;
      debounce_count <= '0;
      long_count     <= '0;
    end else if (step) begin
      phase          <= phase_next;
      column         <= column_next;
      held_row       <= held_row_next;
      debounce_count <= debounce_count_next;
      long_count     <= long_count_next;
    end
  end

endmodule

`default_nettype wire

### sv/key_matrix_scan_debounce.sv
// key_matrix_scan_debounce: top level with apb register file, sample register and
// result register; depends on kmsd_pkg, kmsd_rowcls, kmsd_seq
`timescale 1ns / 1ps
`default_nettype none

// channel   | handshake            | payload
// ----------+----------------------+----------------------------------------------
// input     | in_valid / in_ready  | row_bits (one request = one scan tick)
// result    | out_valid / out_ready| column_index, event_valid, event_pressed,
//           |                      | event_long, button_code, watched_held
// config    | apb psel/penable     | paddr, pwdata, prdata (regs at 0x0, 0x4, 0x8)
//
// a request waits in the sample register (row class stored) and
// is folded into the sequencer state as it moves into the result register;
// sustained rate is one request per cycle while out_ready is held high.
// the result register and sample register each advance whenever the stage
// after them is empty or being drained, so a stalled result holds at most
// one request behind it. reset is synchronous and clears the sequencer state,
// the valid flags and the config registers to their defaults.

module key_matrix_scan_debounce (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // sample channel
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [7:0]                     row_bits,
  // result channel
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [kmsd_pkg::COL_W-1:0]          column_index,
  output logic                                event_valid,
  output logic                                event_pressed,
  output logic                                event_long,
  output logic [kmsd_pkg::CODE_W-1:0]         button_code,
  output logic                                watched_held,
  // config port
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [kmsd_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [kmsd_pkg::PDATA_W-1:0]   pwdata,
  output logic      [kmsd_pkg::PDATA_W-1:0]   prdata,
  output logic                                pready
);

  kmsd_pkg::cfg_t               cfg;
  logic                         cfg_wr;
  logic [1:0]                   reg_idx;

  logic [kmsd_pkg::ROW_W-1:0]   row_cls_in;
  logic [kmsd_pkg::ROW_W-1:0]   sample_cls;
  logic                         sample_valid;
  logic                         advance;

  kmsd_pkg::res_t               res_comb;
  kmsd_pkg::res_t               res_reg;

  // ---------------- config registers ----------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks    <= kmsd_pkg::DEBOUNCE_RESET;
      cfg.long_press_ticks  <= kmsd_pkg::LONG_RESET;
      cfg.watched_scan_code <= kmsd_pkg::WATCHED_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        kmsd_pkg::REG_DEBOUNCE: cfg.debounce_ticks    <= pwdata[kmsd_pkg::DB_W-1:0];
        kmsd_pkg::REG_LONG:     cfg.long_press_ticks  <= pwdata[kmsd_pkg::LP_W-1:0];
        kmsd_pkg::REG_WATCHED:  cfg.watched_scan_code <= pwdata[kmsd_pkg::SC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      kmsd_pkg::REG_DEBOUNCE: prdata = 32'(cfg.debounce_ticks);
      kmsd_pkg::REG_LONG:     prdata = 32'(cfg.long_press_ticks);
      kmsd_pkg::REG_WATCHED:  prdata = 32'(cfg.watched_scan_code);
      default:                prdata = '0;
    endcase
  end

  // ---------------- sample register ----------------
  kmsd_rowcls u_rowcls (
    .row_bits (row_bits),
    .row_cls  (row_cls_in)
  );

  // sequencer steps as the sample moves into a free result slot
  assign advance  = sample_valid && (!out_valid || out_ready);
  assign in_ready = !sample_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (in_ready) begin
      sample_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sample_cls <= row_cls_in;
    end
  end

  // ---------------- sequencer ----------------
  kmsd_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .row_cls (sample_cls),
    .cfg     (cfg),
    .res     (res_comb)
  );

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_reg <= res_comb;
    end
  end

  assign column_index  = res_reg.column_index;
  assign event_valid   = res_reg.event_valid;
  assign event_pressed = res_reg.event_pressed;
  assign event_long    = res_reg.event_long;
  assign button_code   = res_reg.button_code;
  assign watched_held  = res_reg.watched_held;

endmodule

`default_nettype wire
